// ===== hdl/framed_delta_packet_accumulator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the framed delta packet accumulator
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_DELTA_PACKET_ACCUMULATOR_TOP_DEFINES_SVH
`define FRAMED_DELTA_PACKET_ACCUMULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FDPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FDPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fdpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fdpa_pkg
// Framing constants, status codes and beat layout for the delta accumulator.
// ----------------------------------------------------------------------------
package fdpa_pkg;

   localparam logic [7:0] HDR_BYTE  = 8'hAA;
   localparam logic [7:0] TAIL_BYTE = 8'h55;

   localparam logic signed [31:0] POS_RESET = 32'sd3000;

   // frame_status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_TAIL = 2'd3;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;   // 2 + 32 + 32 = 66, padded to 9 bytes

   typedef logic [7:0] byte_type;

endpackage

// ===== hdl/framed_delta_packet_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// framed_delta_packet_accumulator_top
// Byte-stream frame parser (0xAA, 4 payload, checksum, 0x55) feeding two
// saturating position accumulators with sign-magnitude deltas.
// ----------------------------------------------------------------------------
// Path: a req beat is taken into the input register, then into the result
//   register, which drives rsp_tvalid.
// Throughput: 1 byte per cycle unless rsp_tready stalls; each position
//   update is a 33-bit add and saturate between input and result regs.
// Reset: pipeline empties, parser hunts for a header, both positions = 3000.
module framed_delta_packet_accumulator_top
   import fdpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] frame_status, [33:2] x_position, [65:34] y_position, [71:66] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_P0   = 3'd1;
   localparam logic [2:0] PH_P1   = 3'd2;
   localparam logic [2:0] PH_P2   = 3'd3;
   localparam logic [2:0] PH_P3   = 3'd4;
   localparam logic [2:0] PH_SUM  = 3'd5;
   localparam logic [2:0] PH_TAIL = 3'd6;

   logic                  s1_valid_ff;
   byte_type              s1_byte_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            status_ff, status_in;
   logic [2:0]            phase_ff, phase_in;
   byte_type              payload_ff [5];
   logic signed [31:0]    x_acc_ff, x_acc_in;
   logic signed [31:0]    y_acc_ff, y_acc_in;

   logic                  out_take;
   logic                  s1_adv;
   byte_type              csum;
   logic [2:0]            wr_idx;

   function automatic logic signed [16:0] sm_delta(input byte_type hi, input byte_type lo);
      logic signed [16:0] mag;
      mag = {2'b00, hi[6:0], lo};
      return hi[7] ? -mag : mag;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                  input logic signed [16:0] d);
      logic signed [32:0] s;
      s = {acc[31], acc} + {{16{d[16]}}, d};
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[31:0];
   endfunction

   assign out_take   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_take;
   assign req_tready = !s1_valid_ff || out_take;

   assign csum   = payload_ff[0] + payload_ff[1] + payload_ff[2] + payload_ff[3];
   assign wr_idx = phase_ff - PH_P0;

   always_comb begin
      phase_in  = phase_ff;
      status_in = ST_NONE;
      x_acc_in  = x_acc_ff;
      y_acc_in  = y_acc_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (s1_byte_ff == HDR_BYTE) phase_in = PH_P0;
         end
         PH_P0, PH_P1, PH_P2, PH_P3, PH_SUM: begin
            phase_in = phase_ff + 3'd1;
         end
         PH_TAIL: begin
            phase_in = PH_HUNT;
            if (s1_byte_ff != TAIL_BYTE) begin
               status_in = ST_TAIL;
            end else if (csum == payload_ff[4]) begin
               status_in = ST_OK;
               x_acc_in  = sat_add(x_acc_ff, sm_delta(payload_ff[0], payload_ff[1]));
               y_acc_in  = sat_add(y_acc_ff, sm_delta(payload_ff[2], payload_ff[3]));
            end else begin
               status_in = ST_SUM;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         x_acc_ff     <= POS_RESET;
         y_acc_ff     <= POS_RESET;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (out_take) rsp_valid_ff <= s1_valid_ff;
         if (s1_adv) begin
            phase_ff <= phase_in;
            x_acc_ff <= x_acc_in;
            y_acc_ff <= y_acc_in;
         end
      end
   end

   // payload store is always rewritten before the tail is checked
   always_ff @(posedge clock) begin
      if (req_tready) s1_byte_ff <= req_tdata;
      if (s1_adv) begin
         status_ff <= status_in;
         if (phase_ff >= PH_P0 && phase_ff <= PH_SUM) payload_ff[wr_idx] <= s1_byte_ff;
      end
   end

   // positions move only together with the result register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, y_acc_ff, x_acc_ff, status_ff};

endmodule

// ===== hdl/fdpa_checker.sv =====
// ----------------------------------------------------------------------------
// fdpa_checker
// Port-level checks on the result stream of the delta accumulator.
// ----------------------------------------------------------------------------
`include "framed_delta_packet_accumulator_top_defines.svh"

module fdpa_checker
   import fdpa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               rsp_beat;
   logic               req_beat;
   logic [1:0]         status;
   logic signed [31:0] last_x_ff;
   logic signed [31:0] last_y_ff;
   logic [1:0]         last_status_ff;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign status   = rsp_tdata[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff      <= POS_RESET;
         last_y_ff      <= POS_RESET;
         last_status_ff <= ST_NONE;
      end else if (rsp_beat) begin
         last_x_ff      <= rsp_tdata[33:2];
         last_y_ff      <= rsp_tdata[65:34];
         last_status_ff <= status;
      end
   end

   `FDPA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   `FDPA_ASSERT_NOW(a_pos_hold, rsp_beat && status != ST_OK,
      rsp_tdata[33:2] == last_x_ff && rsp_tdata[65:34] == last_y_ff,
      "positions moved without an accepted frame")

   `FDPA_ASSERT_NOW(a_frame_gap, rsp_beat && last_status_ff != ST_NONE,
      status == ST_NONE, "two frame ends on consecutive beats")

   `FDPA_ASSERT_NOW(a_pad_zero, rsp_tvalid || req_beat,
      !rsp_tvalid || rsp_tdata[71:66] == 6'b0, "rsp padding bits not zero")

endmodule

bind framed_delta_packet_accumulator_top fdpa_checker u_fdpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
